// ----- src/tast_pkg.sv -----
`default_nettype none
package tast_pkg;

	localparam int ANG_W = 29;
	localparam int CFG_W = 24;
	localparam int SET_W = 8;
	localparam int SEC_W = 16;

	// register indexes on the configuration port
	localparam logic [2:0] REG_AZ_RATE   = 3'd0;
	localparam logic [2:0] REG_AZ_ACCEL  = 3'd1;
	localparam logic [2:0] REG_AZ_DECEL  = 3'd2;
	localparam logic [2:0] REG_AZ_SETTLE = 3'd3;
	localparam logic [2:0] REG_EL_RATE   = 3'd4;
	localparam logic [2:0] REG_EL_ACCEL  = 3'd5;
	localparam logic [2:0] REG_EL_DECEL  = 3'd6;
	localparam logic [2:0] REG_EL_SETTLE = 3'd7;

	localparam logic [CFG_W-1:0] RATE_RST   = 24'd878453;
	localparam logic [CFG_W-1:0] ACCEL_RST  = 24'd292818;
	localparam logic [SET_W-1:0] SETTLE_RST = 8'd0;

	// per-axis seconds with bit 16 meaning clamped
	localparam logic [SEC_W:0] SECS_SAT = {1'b1, {SEC_W{1'b0}}};

	typedef struct packed {
		logic [CFG_W-1:0] rate;   // zero already replaced by one
		logic [47:0]      ae;     // accel * decel
		logic [24:0]      aplus;  // accel + decel
		logic [72:0]      rrae;   // rate^2 * (accel + decel)
		logic [SET_W-1:0] settle;
	} axis_cfg_t;

endpackage
`default_nettype wire

// ----- src/tast_div_pipe.sv -----
`default_nettype none
module tast_div_pipe #(
	parameter int DW = 24,
	parameter int NB = 48,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [NB-1:0] in_bits,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [NB-1:0]      out_quot,
	output logic               out_inexact,
	output logic [PW-1:0]      out_pay
);

	logic [NB:1]   vld_s;
	logic [DW-1:0] rem_s [1:NB];
	logic [NB-1:0] nq_s  [1:NB];
	logic [PW-1:0] pay_s [1:NB];

	logic [NB-1:0] vld_n;
	logic [DW-1:0] rem_n [0:NB-1];
	logic [NB-1:0] nq_n  [0:NB-1];
	logic [PW-1:0] pay_n [0:NB-1];

	// one quotient bit per stage: numerator bits leave at the top, quotient bits enter below
	for (genvar i = 0; i < NB; i++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [NB-1:0] nq_i;
		logic [DW:0]   trial;
		logic          ge;
		if (i == 0) begin : g_first
			assign vld_n[i] = in_valid;
			assign rem_i    = in_rem;
			assign nq_i     = in_bits;
			assign pay_n[i] = in_pay;
		end else begin : g_next
			assign vld_n[i] = vld_s[i];
			assign rem_i    = rem_s[i];
			assign nq_i     = nq_s[i];
			assign pay_n[i] = pay_s[i];
		end
		assign trial    = {rem_i, nq_i[NB-1]};
		assign ge       = trial >= {1'b0, divisor};
		assign rem_n[i] = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
		assign nq_n[i]  = {nq_i[NB-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NB; k++) begin
			rem_s[k+1] <= rem_n[k];
			nq_s[k+1]  <= nq_n[k];
			pay_s[k+1] <= pay_n[k];
		end
	end

	assign out_valid   = vld_s[NB];
	assign out_quot    = nq_s[NB];
	assign out_inexact = rem_s[NB] != '0;
	assign out_pay     = pay_s[NB];

endmodule
`default_nettype wire

// ----- src/tast_sqrt_pipe.sv -----
`default_nettype none
module tast_sqrt_pipe #(
	parameter int XW = 66,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [XW-1:0] in_rad,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [XW/2-1:0]    out_root,
	output logic               out_inexact,
	output logic [PW-1:0]      out_pay
);

	localparam int N = XW / 2;

	logic [N:1]    vld_s;
	logic [N+1:0]  rem_s  [1:N];
	logic [N-1:0]  root_s [1:N];
	logic [XW-1:0] x_s    [1:N];
	logic [PW-1:0] pay_s  [1:N];

	logic [N-1:0]  vld_n;
	logic [N+1:0]  rem_n  [0:N-1];
	logic [N-1:0]  root_n [0:N-1];
	logic [XW-1:0] x_n    [0:N-1];
	logic [PW-1:0] pay_n  [0:N-1];

	// one root bit per stage, two radicand bits brought down each time
	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [N+1:0]  rem_i;
		logic [N-1:0]  root_i;
		logic [XW-1:0] x_i;
		logic [N+3:0]  r4;
		logic [N+3:0]  trial;
		logic          ge;
		if (i == 0) begin : g_first
			assign vld_n[i] = in_valid;
			assign rem_i    = '0;
			assign root_i   = '0;
			assign x_i      = in_rad;
			assign pay_n[i] = in_pay;
		end else begin : g_next
			assign vld_n[i] = vld_s[i];
			assign rem_i    = rem_s[i];
			assign root_i   = root_s[i];
			assign x_i      = x_s[i];
			assign pay_n[i] = pay_s[i];
		end
		assign r4        = {rem_i, x_i[XW-1:XW-2]};
		assign trial     = {2'b00, root_i, 2'b01};
		assign ge        = r4 >= trial;
		assign rem_n[i]  = ge ? (N+2)'(r4 - trial) : r4[N+1:0];
		assign root_n[i] = {root_i[N-2:0], ge};
		assign x_n[i]    = {x_i[XW-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			rem_s[k+1]  <= rem_n[k];
			root_s[k+1] <= root_n[k];
			x_s[k+1]    <= x_n[k];
			pay_s[k+1]  <= pay_n[k];
		end
	end

	assign out_valid   = vld_s[N];
	assign out_root    = root_s[N];
	assign out_inexact = rem_s[N] != '0;
	assign out_pay     = pay_s[N];

endmodule
`default_nettype wire

// ----- src/tast_cfg.sv -----
`default_nettype none
module tast_cfg import tast_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  seq_busy,
	output axis_cfg_t             az_cfg,
	output axis_cfg_t             el_cfg,
	output logic [F+24:0]         az_ramp,
	output logic [F+24:0]         el_ramp
);

	localparam int NQ = CFG_W + F;
	localparam int CW = $clog2(NQ);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;

	logic [CFG_W-1:0] rate_q   [0:1];
	logic [CFG_W-1:0] accel_q  [0:1];
	logic [CFG_W-1:0] decel_q  [0:1];
	logic [SET_W-1:0] settle_q [0:1];

	logic [CFG_W-1:0] eff_r [0:1];
	logic [CFG_W-1:0] eff_a [0:1];
	logic [CFG_W-1:0] eff_e [0:1];

	logic [47:0] ae_q    [0:1];
	logic [24:0] aplus_q [0:1];
	logic [47:0] rr_q    [0:1];
	logic [48:0] rrl_q   [0:1];
	logic [48:0] rrh_q   [0:1];
	logic [72:0] rrae_q  [0:1];

	logic [1:0]    state_q;
	logic [1:0]    job_q;
	logic [CW-1:0] cnt_q;
	logic [24:0]   rem_q;
	logic [NQ-1:0] nq_q;
	logic [NQ-1:0] ramp_q [0:3];

	logic [CFG_W-1:0] job_r;
	logic [CFG_W-1:0] job_d;
	logic [24:0]      dvs;
	logic [25:0]      trial;
	logic             ge;
	logic [24:0]      rem_n;
	logic [NQ-1:0]    nq_n;
	logic             last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ax = 0; ax < 2; ax++) begin
				rate_q[ax]   <= RATE_RST;
				accel_q[ax]  <= ACCEL_RST;
				decel_q[ax]  <= ACCEL_RST;
				settle_q[ax] <= SETTLE_RST;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AZ_RATE:   rate_q[0]   <= cfg_data;
				REG_AZ_ACCEL:  accel_q[0]  <= cfg_data;
				REG_AZ_DECEL:  decel_q[0]  <= cfg_data;
				REG_AZ_SETTLE: settle_q[0] <= cfg_data[SET_W-1:0];
				REG_EL_RATE:   rate_q[1]   <= cfg_data;
				REG_EL_ACCEL:  accel_q[1]  <= cfg_data;
				REG_EL_DECEL:  decel_q[1]  <= cfg_data;
				REG_EL_SETTLE: settle_q[1] <= cfg_data[SET_W-1:0];
			endcase
		end
	end

	// a zero rate, acceleration or deceleration behaves as one
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			eff_r[ax] = (rate_q[ax] == '0) ? CFG_W'(1) : rate_q[ax];
			eff_a[ax] = (accel_q[ax] == '0) ? CFG_W'(1) : accel_q[ax];
			eff_e[ax] = (decel_q[ax] == '0) ? CFG_W'(1) : decel_q[ax];
		end
	end

	// derived products, settled long before the ramp divisions end
	always_ff @(posedge clk) begin
		for (int ax = 0; ax < 2; ax++) begin
			ae_q[ax]    <= {24'b0, eff_a[ax]} * {24'b0, eff_e[ax]};
			aplus_q[ax] <= {1'b0, eff_a[ax]} + {1'b0, eff_e[ax]};
			rr_q[ax]    <= {24'b0, eff_r[ax]} * {24'b0, eff_r[ax]};
			rrl_q[ax]   <= {25'b0, rr_q[ax][23:0]} * {24'b0, aplus_q[ax]};
			rrh_q[ax]   <= {25'b0, rr_q[ax][47:24]} * {24'b0, aplus_q[ax]};
			rrae_q[ax]  <= {rrh_q[ax], 24'b0} + {24'b0, rrl_q[ax]};
		end
	end

	// shared serial divider for the four ramp times ceil(rate * 2^F / (2 * a)), a the accel or decel of each axis
	assign job_r = eff_r[job_q[1]];
	assign job_d = job_q[0] ? eff_e[job_q[1]] : eff_a[job_q[1]];
	assign dvs   = {job_d, 1'b0};
	assign trial = {rem_q, nq_q[NQ-1]};
	assign ge    = trial >= {1'b0, dvs};
	assign rem_n = ge ? 25'(trial - {1'b0, dvs}) : trial[24:0];
	assign nq_n  = {nq_q[NQ-2:0], ge};
	assign last  = (state_q == ST_ITER) && (cnt_q == CW'(NQ - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			job_q   <= '0;
			cnt_q   <= '0;
		end else if (cfg_valid) begin
			state_q <= ST_LOAD;
			job_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						job_q   <= job_q + 1'b1;
						state_q <= (job_q == 2'd3) ? ST_IDLE : ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			rem_q <= '0;
			nq_q  <= {job_r, {F{1'b0}}};
		end else begin
			rem_q <= rem_n;
			nq_q  <= nq_n;
		end
		if (last) begin
			ramp_q[job_q] <= nq_n + NQ'(rem_n != '0);
		end
	end

	assign seq_busy = state_q != ST_IDLE;

	assign az_cfg = '{rate: eff_r[0], ae: ae_q[0], aplus: aplus_q[0], rrae: rrae_q[0],
		settle: settle_q[0]};
	assign el_cfg = '{rate: eff_r[1], ae: ae_q[1], aplus: aplus_q[1], rrae: rrae_q[1],
		settle: settle_q[1]};
	assign az_ramp = (F+25)'(ramp_q[0]) + (F+25)'(ramp_q[1]);
	assign el_ramp = (F+25)'(ramp_q[2]) + (F+25)'(ramp_q[3]);

endmodule
`default_nettype wire

// ----- src/tast_axis.sv -----
`default_nettype none
module tast_axis import tast_pkg::*; #(
	parameter int F = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    op,
	input  wire logic signed [ANG_W-1:0] old_ang,
	input  wire logic signed [ANG_W-1:0] new_ang,
	input  wire axis_cfg_t               cfg,
	input  wire logic [F+24:0]           ramp_sum,
	output logic                         out_valid,
	output logic [SEC_W:0]               out_secs
);

	localparam int NB = 32 + 2 * F;   // divider stages, both paths
	localparam int QW = 29 + F;       // useful trapezoid quotient bits
	localparam int XW = 34 + 2 * F;   // radicand width
	localparam int RW = XW / 2;
	localparam int TW = 31 + F;
	localparam logic [TW-1:0] RND = {{(TW-F){1'b0}}, {F{1'b1}}};

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic              op_s1, op_s2, op_s3, op_s4, op_s5, op_s6;
	logic signed [29:0] diff_s1;
	logic [ANG_W-1:0]  d_s2, d_s3, d_s4, d_s5;
	logic [53:0]       prod_s3, prod_s4, prod_s5;
	logic [52:0]       pl_s3, ph_s3;
	logic [76:0]       lhs_s4;
	logic              sat_s4, sat_s5, sat_s6;
	logic              tri_s5, tri_s6;
	logic [NB:0]       qq_s6;
	logic [F+29:0]     tt_s6;
	logic [TW-1:0]     t_s7;
	logic              over_s7;
	logic [SEC_W:0]    secs_s8;

	logic              tdv, tdx, pdv, pdx, sqv, sqx;
	logic [NB-1:0]     tdq, pdq;
	logic              td_sat;
	logic [1:0]        pd_pay;
	logic [RW-1:0]     root;
	logic [F+32:0]     sq_pay;
	logic [F+29:0]     sq_tt;
	logic              sq_op, sq_tri, sq_sat;
	logic [TW-1:0]     t_sel;
	logic [TW-1:0]     t_set;
	logic [TW-1:0]     rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= {old_ang[ANG_W-1], old_ang} - {new_ang[ANG_W-1], new_ang};
		op_s1   <= op;

		d_s2  <= diff_s1[29] ? ANG_W'(-diff_s1) : diff_s1[ANG_W-1:0];
		op_s2 <= op_s1;

		// 2*D*(A+E) is the divider numerator, 2*D*A*E decides the profile shape
		prod_s3 <= {25'b0, d_s2} * {29'b0, cfg.aplus};
		pl_s3   <= {24'b0, d_s2} * {29'b0, cfg.ae[23:0]};
		ph_s3   <= {24'b0, d_s2} * {29'b0, cfg.ae[47:24]};
		d_s3    <= d_s2;
		op_s3   <= op_s2;

		lhs_s4  <= {ph_s3, 24'b0} + {24'b0, pl_s3};
		// integer part of the squared time would not fit in 32 bits
		sat_s4  <= {25'b0, prod_s3[53:31]} >= cfg.ae;
		prod_s4 <= prod_s3;
		d_s4    <= d_s3;
		op_s4   <= op_s3;

		tri_s5  <= {lhs_s4, 1'b0} < {5'b0, cfg.rrae};
		sat_s5  <= sat_s4;
		prod_s5 <= prod_s4;
		d_s5    <= d_s4;
		op_s5   <= op_s4;
	end

	// squared time in 2F-bit fixed point
	tast_div_pipe #(.DW(48), .NB(NB), .PW(1)) u_tri_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s5),
		.in_rem     ({25'b0, prod_s5[53:31]}),
		.in_bits    ({prod_s5[30:0], 1'b0, {(2*F){1'b0}}}),
		.divisor    (cfg.ae),
		.in_pay     (sat_s5),
		.out_valid  (tdv),
		.out_quot   (tdq),
		.out_inexact(tdx),
		.out_pay    (td_sat)
	);

	// cruise time, leading zeros only pad the depth to match
	tast_div_pipe #(.DW(CFG_W), .NB(NB), .PW(2)) u_trap_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s5),
		.in_rem     ('0),
		.in_bits    ({{(3+F){1'b0}}, d_s5, {F{1'b0}}}),
		.divisor    (cfg.rate),
		.in_pay     ({op_s5, tri_s5}),
		.out_valid  (pdv),
		.out_quot   (pdq),
		.out_inexact(pdx),
		.out_pay    (pd_pay)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= tdv & pdv;
		end
	end

	always_ff @(posedge clk) begin
		qq_s6  <= {1'b0, tdq} + (NB+1)'(tdx);
		tt_s6  <= (F+30)'(pdq[QW-1:0]) + (F+30)'(pdx) + (F+30)'(ramp_sum);
		op_s6  <= pd_pay[1];
		tri_s6 <= pd_pay[0];
		sat_s6 <= td_sat;
	end

	tast_sqrt_pipe #(.XW(XW), .PW(F+33)) u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s6),
		.in_rad     ({1'b0, qq_s6}),
		.in_pay     ({tt_s6, op_s6, tri_s6, sat_s6}),
		.out_valid  (sqv),
		.out_root   (root),
		.out_inexact(sqx),
		.out_pay    (sq_pay)
	);

	assign {sq_tt, sq_op, sq_tri, sq_sat} = sq_pay;
	assign t_sel = sq_tri ? (TW'(root) + TW'(sqx)) : TW'(sq_tt);
	assign t_set = sq_op ? '0 : TW'({cfg.settle, {F{1'b0}}});
	assign rnd   = t_s7 + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= sqv;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		t_s7    <= t_sel + t_set;
		over_s7 <= sq_tri & sq_sat;
		secs_s8 <= (over_s7 || (rnd[TW-1:F+SEC_W] != '0)) ? SECS_SAT :
			{1'b0, rnd[F+SEC_W-1:F]};
	end

	assign out_valid = v_s8;
	assign out_secs  = secs_s8;

endmodule
`default_nettype wire

// ----- src/two_axis_slew_time.sv -----
// channel   signals                                          transfer
// command   start, busy, op, old_az, new_az, old_el, new_el  start & !busy
// result    done, slew_seconds, saturated                    done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid & cfg_ready
//
// one command per cycle while busy is low; done follows the command transfer by the depth
// of the bit-per-stage divider and square root pipelines
// after reset and after every register write busy stays high
// while one shared serial divider works out the ramp times
// the result side has no back-pressure and the pipeline never stalls
`default_nettype none
module two_axis_slew_time import tast_pkg::*; #(
	parameter int TIME_FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    op,
	input  wire logic signed [ANG_W-1:0] old_az,
	input  wire logic signed [ANG_W-1:0] new_az,
	input  wire logic signed [ANG_W-1:0] old_el,
	input  wire logic signed [ANG_W-1:0] new_el,
	output logic                         done,
	output logic [SEC_W-1:0]             slew_seconds,
	output logic                         saturated,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [2:0]              cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	localparam int F = TIME_FRAC_BITS;

	logic           seq_busy;
	logic           go;
	axis_cfg_t      az_cfg, el_cfg;
	logic [F+24:0]  az_ramp, el_ramp;
	logic           az_v, el_v;
	logic [SEC_W:0] az_secs, el_secs;
	logic [SEC_W:0] worst;

	tast_cfg #(.F(F)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.seq_busy (seq_busy),
		.az_cfg   (az_cfg),
		.el_cfg   (el_cfg),
		.az_ramp  (az_ramp),
		.el_ramp  (el_ramp)
	);

	assign cfg_ready = 1'b1;
	// no command in the same cycle as a register write
	assign busy = seq_busy | cfg_valid;
	assign go   = start & ~busy;

	tast_axis #(.F(F)) u_az (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (go),
		.op       (op),
		.old_ang  (old_az),
		.new_ang  (new_az),
		.cfg      (az_cfg),
		.ramp_sum (az_ramp),
		.out_valid(az_v),
		.out_secs (az_secs)
	);

	tast_axis #(.F(F)) u_el (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (go),
		.op       (op),
		.old_ang  (old_el),
		.new_ang  (new_el),
		.cfg      (el_cfg),
		.ramp_sum (el_ramp),
		.out_valid(el_v),
		.out_secs (el_secs)
	);

	assign worst = (az_secs > el_secs) ? az_secs : el_secs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= az_v & el_v;
		end
	end

	always_ff @(posedge clk) begin
		slew_seconds <= worst[SEC_W] ? {SEC_W{1'b1}} : worst[SEC_W-1:0];
		saturated    <= worst[SEC_W];
	end

endmodule
`default_nettype wire
